@@ rtl/lobm_pkg.sv @@
// Package for the limit order book matcher: opcodes, event codes, item types,
// engine states and default sizes. It depends on nothing.
package lobm_pkg;

  localparam int unsigned SideDepthDef = 32;
  localparam int unsigned PriceBitsDef = 32;

  localparam logic [1:0] OP_BUY    = 2'd0;
  localparam logic [1:0] OP_SELL   = 2'd1;
  localparam logic [1:0] OP_CANCEL = 2'd2;

  localparam logic [2:0] EV_EXECUTED = 3'd0;
  localparam logic [2:0] EV_ADDED    = 3'd1;
  localparam logic [2:0] EV_CANCELED = 3'd2;
  localparam logic [2:0] EV_REJECTED = 3'd3;
  localparam logic [2:0] EV_FULL     = 3'd4;

  typedef enum logic [1:0] {
    KIND_BUY,
    KIND_SELL,
    KIND_CANCEL
  } item_kind_e;

  typedef struct packed {
    item_kind_e  kind;
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] qty;
  } item_t;

  typedef struct packed {
    logic avail;
    logic pop;
  } queue_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE
  } back_state_e;

endpackage

@@ rtl/lobm_front.sv @@
// Front part of the matcher: takes commands, drops the ones that do nothing and
// holds the rest in a two-entry queue. It depends on lobm_pkg.
module lobm_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          opcode_i,
  input  logic [31:0]         order_id_i,
  input  logic [31:0]         limit_price_i,
  input  logic [31:0]         quantity_i,
  input  logic                pop_i,
  output lobm_pkg::queue_ctl_t ctl_o,
  output lobm_pkg::item_t     item_o
);

  lobm_pkg::item_t buf_q [2];
  logic            wr_ptr_q, wr_ptr_d;
  logic            rd_ptr_q, rd_ptr_d;
  logic [1:0]      count_q, count_d;
  logic            keep;
  logic            push;
  lobm_pkg::item_t item_in;

  always_comb begin
    item_in.id    = order_id_i;
    item_in.price = limit_price_i;
    item_in.qty   = quantity_i;
    item_in.kind  = lobm_pkg::KIND_CANCEL;
    keep          = 1'b0;
    case (opcode_i)
      lobm_pkg::OP_BUY: begin
        item_in.kind = lobm_pkg::KIND_BUY;
        keep         = (quantity_i != 32'd0);
      end
      lobm_pkg::OP_SELL: begin
        item_in.kind = lobm_pkg::KIND_SELL;
        keep         = (quantity_i != 32'd0);
      end
      lobm_pkg::OP_CANCEL: begin
        keep = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign busy       = (count_q == 2'd2);
  assign push       = start && !busy && keep;
  assign ctl_o.avail = (count_q != 2'd0);
  assign ctl_o.pop   = pop_i && ctl_o.avail;
  assign item_o     = buf_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ ctl_o.pop;
    count_d  = count_q + 2'(push) - 2'(ctl_o.pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      buf_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

@@ rtl/lobm_back.sv @@
// Back part of the matcher: the order book memory, the scan engine that finds
// the best resting order or a cancel target, and the result registers.
// It depends on lobm_pkg.
module lobm_back #(
  parameter int unsigned SIDE_DEPTH = lobm_pkg::SideDepthDef,
  parameter int unsigned PRICE_BITS = lobm_pkg::PriceBitsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  lobm_pkg::queue_ctl_t ctl_i,
  input  lobm_pkg::item_t      item_i,
  output logic                 pop_o,
  output logic                 result_valid_o,
  output logic [2:0]           event_kind_o,
  output logic [31:0]          resting_id_o,
  output logic [31:0]          active_id_o,
  output logic [31:0]          execution_number_o,
  output logic [31:0]          trade_price_o,
  output logic [31:0]          trade_quantity_o,
  output logic                 is_sell_side_o,
  output logic                 last_o
);

  localparam int unsigned NSlots = 2 * SIDE_DEPTH;
  localparam int unsigned AW     = $clog2(NSlots);
  localparam int unsigned JW     = $clog2(SIDE_DEPTH);
  localparam int unsigned CW     = $clog2(SIDE_DEPTH + 1);

  function automatic logic [AW-1:0] slot_addr(input logic buys, input logic [JW-1:0] j);
    slot_addr = buys ? (AW'(SIDE_DEPTH) + AW'(j)) : AW'(j);
  endfunction

  logic [31:0]           mem_id    [NSlots];
  logic [PRICE_BITS-1:0] mem_price [NSlots];
  logic [31:0]           mem_rem   [NSlots];
  logic [31:0]           mem_exec  [NSlots];
  logic [31:0]           mem_arr   [NSlots];

  logic [31:0]           rd_id_q, rd_rem_q, rd_exec_q, rd_arr_q;
  logic [PRICE_BITS-1:0] rd_price_q;
  logic [AW-1:0]         raddr;

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [31:0]           wr_id, wr_rem, wr_exec, wr_arr;
  logic [PRICE_BITS-1:0] wr_price;

  lobm_pkg::back_state_e state_q, state_d;
  lobm_pkg::item_kind_e  kind_q, kind_d;
  logic [31:0]           id_q, id_d;
  logic [PRICE_BITS-1:0] price_q, price_d;
  logic [31:0]           qty_q, qty_d;
  logic                  buys_q, buys_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic                  pend_q, pend_d;
  logic [JW-1:0]         rj_q, rj_d;
  logic                  found_q, found_d;
  logic [JW-1:0]         best_j_q, best_j_d;
  logic [PRICE_BITS-1:0] best_price_q, best_price_d;
  logic [31:0]           best_age_q, best_age_d;
  logic [31:0]           best_id_q, best_id_d;
  logic [31:0]           best_rem_q, best_rem_d;
  logic [31:0]           best_exec_q, best_exec_d;
  logic [31:0]           best_arr_q, best_arr_d;
  logic                  free_q, free_d;
  logic [JW-1:0]         free_j_q, free_j_d;
  logic [31:0]           arr_cnt_q, arr_cnt_d;
  logic [NSlots-1:0]     valid_q, valid_d;

  logic                  ev_q, ev_d;
  logic [2:0]            ev_kind_q, ev_kind_d;
  logic [31:0]           ev_rid_q, ev_rid_d;
  logic [31:0]           ev_aid_q, ev_aid_d;
  logic [31:0]           ev_exn_q, ev_exn_d;
  logic [31:0]           ev_price_q, ev_price_d;
  logic [31:0]           ev_qty_q, ev_qty_d;
  logic                  ev_sell_q, ev_sell_d;
  logic                  ev_last_q, ev_last_d;

  logic                  scan_done;
  logic                  is_order;
  logic                  sell_in;
  logic                  cand;
  logic                  better;
  logic [31:0]           age;
  logic [AW-1:0]         cand_addr;
  logic [AW-1:0]         own_addr;

  assign scan_done = (cnt_q == CW'(SIDE_DEPTH)) && !pend_q;
  assign is_order  = (kind_q != lobm_pkg::KIND_CANCEL);
  assign sell_in   = (kind_q == lobm_pkg::KIND_SELL);
  assign raddr     = (cnt_q < CW'(SIDE_DEPTH)) ? slot_addr(buys_q, cnt_q[JW-1:0]) : '0;
  assign cand_addr = slot_addr(buys_q, rj_q);
  assign own_addr  = slot_addr(!buys_q, rj_q);
  assign age       = arr_cnt_q - rd_arr_q;

  always_comb begin
    if (!is_order) begin
      cand   = valid_q[cand_addr] && (rd_id_q == id_q);
      better = !found_q || (age > best_age_q);
    end else begin
      cand = valid_q[cand_addr] &&
             (sell_in ? (rd_price_q >= price_q) : (rd_price_q <= price_q));
      if (!found_q) begin
        better = 1'b1;
      end else if (rd_price_q != best_price_q) begin
        better = sell_in ? (rd_price_q > best_price_q) : (rd_price_q < best_price_q);
      end else begin
        better = (age > best_age_q);
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      lobm_pkg::ST_IDLE: begin
        if (ctl_i.avail) begin
          state_d = lobm_pkg::ST_SCAN;
        end
      end
      lobm_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = lobm_pkg::ST_DECIDE;
        end
      end
      lobm_pkg::ST_DECIDE: begin
        state_d = lobm_pkg::ST_IDLE;
        if (is_order && found_q && (qty_q > best_rem_q)) begin
          state_d = lobm_pkg::ST_SCAN;
        end else if (!is_order && !found_q && !buys_q) begin
          state_d = lobm_pkg::ST_SCAN;
        end
      end
      default: begin
        state_d = lobm_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    pop_o        = 1'b0;
    kind_d       = kind_q;
    id_d         = id_q;
    price_d      = price_q;
    qty_d        = qty_q;
    buys_d       = buys_q;
    cnt_d        = cnt_q;
    pend_d       = 1'b0;
    rj_d         = rj_q;
    found_d      = found_q;
    best_j_d     = best_j_q;
    best_price_d = best_price_q;
    best_age_d   = best_age_q;
    best_id_d    = best_id_q;
    best_rem_d   = best_rem_q;
    best_exec_d  = best_exec_q;
    best_arr_d   = best_arr_q;
    free_d       = free_q;
    free_j_d     = free_j_q;
    arr_cnt_d    = arr_cnt_q;
    valid_d      = valid_q;
    we           = 1'b0;
    waddr        = slot_addr(buys_q, best_j_q);
    wr_id        = best_id_q;
    wr_price     = best_price_q;
    wr_rem       = best_rem_q - qty_q;
    wr_exec      = best_exec_q + 32'd1;
    wr_arr       = best_arr_q;
    ev_d         = 1'b0;
    ev_kind_d    = ev_kind_q;
    ev_rid_d     = ev_rid_q;
    ev_aid_d     = ev_aid_q;
    ev_exn_d     = ev_exn_q;
    ev_price_d   = ev_price_q;
    ev_qty_d     = ev_qty_q;
    ev_sell_d    = ev_sell_q;
    ev_last_d    = ev_last_q;
    case (state_q)
      lobm_pkg::ST_IDLE: begin
        if (ctl_i.avail) begin
          pop_o   = 1'b1;
          kind_d  = item_i.kind;
          id_d    = item_i.id;
          price_d = PRICE_BITS'(item_i.price);
          qty_d   = item_i.qty;
          buys_d  = (item_i.kind == lobm_pkg::KIND_SELL);
          cnt_d   = '0;
          found_d = 1'b0;
          free_d  = 1'b0;
        end
      end
      lobm_pkg::ST_SCAN: begin
        if (cnt_q < CW'(SIDE_DEPTH)) begin
          pend_d = 1'b1;
          rj_d   = cnt_q[JW-1:0];
          cnt_d  = cnt_q + CW'(1);
        end
        if (pend_q) begin
          if (cand && better) begin
            found_d      = 1'b1;
            best_j_d     = rj_q;
            best_price_d = rd_price_q;
            best_age_d   = age;
            best_id_d    = rd_id_q;
            best_rem_d   = rd_rem_q;
            best_exec_d  = rd_exec_q;
            best_arr_d   = rd_arr_q;
          end
          if (!free_q && !valid_q[own_addr]) begin
            free_d   = 1'b1;
            free_j_d = rj_q;
          end
        end
      end
      lobm_pkg::ST_DECIDE: begin
        ev_d      = 1'b1;
        ev_rid_d  = id_q;
        ev_aid_d  = 32'd0;
        ev_exn_d  = 32'd0;
        ev_price_d = 32'd0;
        ev_qty_d  = 32'd0;
        ev_sell_d = 1'b0;
        ev_last_d = 1'b1;
        cnt_d     = '0;
        found_d   = 1'b0;
        free_d    = 1'b0;
        if (is_order) begin
          if (found_q) begin
            ev_kind_d  = lobm_pkg::EV_EXECUTED;
            ev_rid_d   = best_id_q;
            ev_aid_d   = id_q;
            ev_exn_d   = best_exec_q;
            ev_price_d = 32'(best_price_q);
            ev_last_d  = (qty_q <= best_rem_q);
            if (qty_q >= best_rem_q) begin
              ev_qty_d = best_rem_q;
              qty_d    = qty_q - best_rem_q;
              valid_d[slot_addr(buys_q, best_j_q)] = 1'b0;
            end else begin
              ev_qty_d = qty_q;
              qty_d    = 32'd0;
              we       = 1'b1;
            end
          end else begin
            ev_price_d = 32'(price_q);
            ev_qty_d   = qty_q;
            ev_sell_d  = sell_in;
            if (free_q) begin
              ev_kind_d = lobm_pkg::EV_ADDED;
              we        = 1'b1;
              waddr     = slot_addr(!buys_q, free_j_q);
              wr_id     = id_q;
              wr_price  = price_q;
              wr_rem    = qty_q;
              wr_exec   = 32'd1;
              wr_arr    = arr_cnt_q;
              arr_cnt_d = arr_cnt_q + 32'd1;
              valid_d[slot_addr(!buys_q, free_j_q)] = 1'b1;
            end else begin
              ev_kind_d = lobm_pkg::EV_FULL;
              ev_rid_d  = 32'd0;
              ev_aid_d  = id_q;
            end
          end
        end else if (found_q) begin
          ev_kind_d = lobm_pkg::EV_CANCELED;
          ev_sell_d = !buys_q;
          valid_d[slot_addr(buys_q, best_j_q)] = 1'b0;
        end else if (!buys_q) begin
          ev_d   = 1'b0;
          buys_d = 1'b1;
        end else begin
          ev_kind_d = lobm_pkg::EV_REJECTED;
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_id[waddr]    <= wr_id;
      mem_price[waddr] <= wr_price;
      mem_rem[waddr]   <= wr_rem;
      mem_exec[waddr]  <= wr_exec;
      mem_arr[waddr]   <= wr_arr;
    end
    rd_id_q    <= mem_id[raddr];
    rd_price_q <= mem_price[raddr];
    rd_rem_q   <= mem_rem[raddr];
    rd_exec_q  <= mem_exec[raddr];
    rd_arr_q   <= mem_arr[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lobm_pkg::ST_IDLE;
      cnt_q     <= '0;
      pend_q    <= 1'b0;
      found_q   <= 1'b0;
      free_q    <= 1'b0;
      arr_cnt_q <= 32'd0;
      valid_q   <= '0;
      ev_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      pend_q    <= pend_d;
      found_q   <= found_d;
      free_q    <= free_d;
      arr_cnt_q <= arr_cnt_d;
      valid_q   <= valid_d;
      ev_q      <= ev_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    id_q         <= id_d;
    price_q      <= price_d;
    qty_q        <= qty_d;
    buys_q       <= buys_d;
    rj_q         <= rj_d;
    best_j_q     <= best_j_d;
    best_price_q <= best_price_d;
    best_age_q   <= best_age_d;
    best_id_q    <= best_id_d;
    best_rem_q   <= best_rem_d;
    best_exec_q  <= best_exec_d;
    best_arr_q   <= best_arr_d;
    free_j_q     <= free_j_d;
    ev_kind_q    <= ev_kind_d;
    ev_rid_q     <= ev_rid_d;
    ev_aid_q     <= ev_aid_d;
    ev_exn_q     <= ev_exn_d;
    ev_price_q   <= ev_price_d;
    ev_qty_q     <= ev_qty_d;
    ev_sell_q    <= ev_sell_d;
    ev_last_q    <= ev_last_d;
  end

  assign result_valid_o     = ev_q;
  assign event_kind_o       = ev_kind_q;
  assign resting_id_o       = ev_rid_q;
  assign active_id_o        = ev_aid_q;
  assign execution_number_o = ev_exn_q;
  assign trade_price_o      = ev_price_q;
  assign trade_quantity_o   = ev_qty_q;
  assign is_sell_side_o     = ev_sell_q;
  assign last_o             = ev_last_q;

endmodule

@@ rtl/limit_order_book_matcher_unit.sv @@
// Top level of the limit order book matcher: joins the command front part and
// the matching back part. It depends on lobm_pkg, lobm_front and lobm_back.
//
// Channel   Direction  Transaction when             Ports
// command   in         start && !busy at clk edge   opcode_i order_id_i limit_price_i quantity_i
// result    out        result_valid_o at clk edge   event_kind_o .. last_o
//
// Every book search reads one slot of a side per cycle from the slot memory, and a decision
// state follows each search; the result of that decision is on the ports in the next cycle.
// A buy or sell searches again after each fill that leaves quantity over; a cancel searches
// the sell side and, if the id is not found there, the buy side.
// Reset clears all slots at once; no clearing pass is needed.
// The front queue holds two commands; busy rises only when it is full.
// Results cannot be held off and leave at most one per cycle.
module limit_order_book_matcher_unit #(
  parameter int unsigned SIDE_DEPTH = lobm_pkg::SideDepthDef,
  parameter int unsigned PRICE_BITS = lobm_pkg::PriceBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] order_id_i,
  input  logic [31:0] limit_price_i,
  input  logic [31:0] quantity_i,
  output logic        result_valid_o,
  output logic [2:0]  event_kind_o,
  output logic [31:0] resting_id_o,
  output logic [31:0] active_id_o,
  output logic [31:0] execution_number_o,
  output logic [31:0] trade_price_o,
  output logic [31:0] trade_quantity_o,
  output logic        is_sell_side_o,
  output logic        last_o
);

  lobm_pkg::queue_ctl_t ctl;
  lobm_pkg::item_t      item;
  logic                 pop;

  lobm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .opcode_i      (opcode_i),
    .order_id_i    (order_id_i),
    .limit_price_i (limit_price_i),
    .quantity_i    (quantity_i),
    .pop_i         (pop),
    .ctl_o         (ctl),
    .item_o        (item)
  );

  lobm_back #(
    .SIDE_DEPTH (SIDE_DEPTH),
    .PRICE_BITS (PRICE_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ctl_i              (ctl),
    .item_i             (item),
    .pop_o              (pop),
    .result_valid_o     (result_valid_o),
    .event_kind_o       (event_kind_o),
    .resting_id_o       (resting_id_o),
    .active_id_o        (active_id_o),
    .execution_number_o (execution_number_o),
    .trade_price_o      (trade_price_o),
    .trade_quantity_o   (trade_quantity_o),
    .is_sell_side_o     (is_sell_side_o),
    .last_o             (last_o)
  );

endmodule

@@ test/limit_order_book_matcher_unit_tb.sv @@
// Self-checking testbench for limit_order_book_matcher_unit: directed and random buy, sell
// and cancel traffic with a price-time book predictor and in-order result checking.
// It depends on lobm_pkg and the limit_order_book_matcher_unit RTL.
module limit_order_book_matcher_unit_tb;

  localparam int Depth = 32;
  localparam int StallLimit = 20000;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] id;
    logic [31:0] price;
    logic [31:0] qty;
  } order_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] rid;
    logic [31:0] aid;
    logic [31:0] exn;
    logic [31:0] price;
    logic [31:0] qty;
    logic        sell;
    logic        last;
  } book_event_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [1:0] opcode_i = '0;
  logic [31:0] order_id_i = '0;
  logic [31:0] limit_price_i = '0;
  logic [31:0] quantity_i = '0;
  logic result_valid_o;
  logic [2:0] event_kind_o;
  logic [31:0] resting_id_o, active_id_o, execution_number_o, trade_price_o;
  logic [31:0] trade_quantity_o;
  logic is_sell_side_o, last_o;

  order_t pending_orders[$];
  book_event_t expected_events[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stim_done = 0;

  // Predictor copy of the book: slots 0..Depth-1 are sells, the rest buys.
  bit          bk_valid[2*Depth];
  logic [31:0] bk_id[2*Depth];
  logic [31:0] bk_price[2*Depth];
  logic [31:0] bk_rem[2*Depth];
  logic [31:0] bk_exn[2*Depth];
  logic [31:0] bk_arr[2*Depth];
  logic [31:0] arrivals = '0;
  logic [31:0] used_ids[$];

  always #4 clk_i = ~clk_i;

  limit_order_book_matcher_unit i_dut (.*);

  function automatic void push_event(logic [2:0] k, logic [31:0] r, logic [31:0] a,
                                     logic [31:0] e, logic [31:0] p, logic [31:0] q,
                                     logic s);
    book_event_t ev;
    ev = '{k, r, a, e, p, q, s, 1'b0};
    expected_events = {expected_events, ev};
  endfunction

  function automatic bit older(int i, int j);
    return (arrivals - bk_arr[i]) > (arrivals - bk_arr[j]);
  endfunction

  function automatic void predict_order(order_t o);
    int opp, own, best, slot, n0;
    bit sell;
    logic [31:0] q;
    n0 = expected_events.size();
    q = o.qty;
    if (o.op == lobm_pkg::OP_BUY || o.op == lobm_pkg::OP_SELL) begin
      sell = (o.op == lobm_pkg::OP_SELL);
      opp = sell ? Depth : 0;
      own = sell ? 0 : Depth;
      while (q > 0) begin
        best = -1;
        for (int i = opp; i < opp + Depth; i++) begin
          if (!bk_valid[i]) continue;
          if (sell ? (bk_price[i] < o.price) : (bk_price[i] > o.price)) continue;
          if (best < 0) best = i;
          else if (bk_price[i] != bk_price[best]) begin
            if (sell ? (bk_price[i] > bk_price[best]) : (bk_price[i] < bk_price[best]))
              best = i;
          end else if (older(i, best)) best = i;
        end
        if (best < 0) break;
        if (q >= bk_rem[best]) begin
          push_event(lobm_pkg::EV_EXECUTED, bk_id[best], o.id, bk_exn[best], bk_price[best],
                     bk_rem[best], 1'b0);
          bk_valid[best] = 0;
          q -= bk_rem[best];
        end else begin
          push_event(lobm_pkg::EV_EXECUTED, bk_id[best], o.id, bk_exn[best], bk_price[best],
                     q, 1'b0);
          bk_rem[best] -= q;
          bk_exn[best] += 1;
          q = 0;
        end
      end
      if (q > 0) begin
        slot = -1;
        for (int i = own; i < own + Depth; i++) begin
          if (!bk_valid[i]) begin
            slot = i;
            break;
          end
        end
        if (slot >= 0) begin
          bk_valid[slot] = 1;
          bk_id[slot] = o.id;
          bk_price[slot] = o.price;
          bk_rem[slot] = q;
          bk_exn[slot] = 1;
          bk_arr[slot] = arrivals;
          arrivals += 1;
          push_event(lobm_pkg::EV_ADDED, o.id, '0, '0, o.price, q, sell);
        end else begin
          push_event(lobm_pkg::EV_FULL, '0, o.id, '0, o.price, q, sell);
        end
      end
    end else if (o.op == lobm_pkg::OP_CANCEL) begin
      best = -1;
      for (int side = 0; side < 2 && best < 0; side++) begin
        for (int i = side * Depth; i < (side + 1) * Depth; i++) begin
          if (bk_valid[i] && bk_id[i] == o.id && (best < 0 || older(i, best))) best = i;
        end
        if (best >= 0) begin
          bk_valid[best] = 0;
          push_event(lobm_pkg::EV_CANCELED, o.id, '0, '0, '0, '0, side == 0);
        end
      end
      if (best < 0) push_event(lobm_pkg::EV_REJECTED, o.id, '0, '0, '0, '0, 1'b0);
    end
    if (expected_events.size() > n0)
      expected_events[expected_events.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  // Driver: bursts of back-to-back commands separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        predict_order(pending_orders.pop_front());
      end
      if (start && busy) begin
      end else if (pending_orders.size() > 0 && gap_left == 0) begin
        start <= 1'b1;
        opcode_i <= pending_orders[0].op;
        order_id_i <= pending_orders[0].id;
        limit_price_i <= pending_orders[0].price;
        quantity_i <= pending_orders[0].qty;
        if (burst_left > 0) burst_left--;
        else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Monitor: results cannot be held off, so every strobe is checked.
  always @(posedge clk_i) begin
    book_event_t w;
    if (rst_ni) begin
      if (result_valid_o || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (result_valid_o) begin
        if (expected_events.size() == 0) begin
          report_mismatch("unexpected result kind", 32'(event_kind_o), '0);
        end else begin
          w = expected_events.pop_front();
          if (event_kind_o !== w.kind) report_mismatch("event_kind", 32'(event_kind_o), 32'(w.kind));
          if (resting_id_o !== w.rid) report_mismatch("resting_id", resting_id_o, w.rid);
          if (active_id_o !== w.aid) report_mismatch("active_id", active_id_o, w.aid);
          if (execution_number_o !== w.exn)
            report_mismatch("execution_number", execution_number_o, w.exn);
          if (trade_price_o !== w.price) report_mismatch("trade_price", trade_price_o, w.price);
          if (trade_quantity_o !== w.qty)
            report_mismatch("trade_quantity", trade_quantity_o, w.qty);
          if (is_sell_side_o !== w.sell)
            report_mismatch("is_sell_side", 32'(is_sell_side_o), 32'(w.sell));
          if (last_o !== w.last) report_mismatch("last", 32'(last_o), 32'(w.last));
        end
      end
    end
  end

  function automatic logic [31:0] pick_id();
    if (used_ids.size() > 0 && $urandom_range(0, 3) != 0)
      return used_ids[$urandom_range(0, used_ids.size() - 1)];
    return $urandom();
  endfunction

  function automatic void queue_order(logic [1:0] op, logic [31:0] id, logic [31:0] price,
                                      logic [31:0] qty);
    order_t o;
    o = '{op, id, price, qty};
    pending_orders = {pending_orders, o};
    if (op != lobm_pkg::OP_CANCEL) used_ids = {used_ids, id};
    if (used_ids.size() > 64) void'(used_ids.pop_front());
  endfunction

  initial begin
    logic [1:0] op;
    logic [31:0] base, q;
    int r;
    // Directed: extremes, ties, partial and exact fills, zero quantity, unused opcode.
    queue_order(lobm_pkg::OP_SELL, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_order(lobm_pkg::OP_SELL, 32'h2, 32'd100, 32'd10);
    queue_order(lobm_pkg::OP_SELL, 32'h3, 32'd100, 32'd5);
    queue_order(lobm_pkg::OP_BUY, 32'hFFFF_FFFF, 32'd100, 32'd3);
    queue_order(lobm_pkg::OP_BUY, 32'h4, 32'd100, 32'd7);
    queue_order(lobm_pkg::OP_BUY, 32'h5, 32'd100, 32'd0);
    queue_order(OpUnused, 32'h6, 32'd1, 32'd1);
    queue_order(lobm_pkg::OP_BUY, 32'h0, 32'd0, 32'd1);
    queue_order(lobm_pkg::OP_SELL, 32'h7, 32'd0, 32'd20);
    queue_order(lobm_pkg::OP_CANCEL, 32'h3, 32'd0, 32'd0);
    queue_order(lobm_pkg::OP_CANCEL, 32'h1, 32'd0, 32'd0);
    queue_order(lobm_pkg::OP_CANCEL, 32'h1, 32'd0, 32'd0);
    queue_order(lobm_pkg::OP_BUY, 32'h8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_order(lobm_pkg::OP_CANCEL, 32'h8, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Fill the buy side to force book-full events, then sweep it.
    for (int i = 0; i < 33; i++) queue_order(lobm_pkg::OP_BUY, 32'h100 + i, 32'd50, 32'd2);
    queue_order(lobm_pkg::OP_SELL, 32'h200, 32'd50, 32'd80);
    queue_order(lobm_pkg::OP_SELL, 32'h201, 32'd10, 32'd1);
    // Random: clustered prices and ids so that fills, ties and cancels are common.
    for (int i = 0; i < 310; i++) begin
      r = $urandom_range(0, 99);
      base = $urandom_range(0, 7) == 0 ? $urandom() : 32'(1000 + $urandom_range(0, 20));
      q = $urandom_range(0, 9) == 0 ? $urandom() : 32'($urandom_range(0, 30));
      if (r < 42) op = lobm_pkg::OP_BUY;
      else if (r < 84) op = lobm_pkg::OP_SELL;
      else if (r < 98) op = lobm_pkg::OP_CANCEL;
      else op = OpUnused;
      queue_order(op, pick_id(), base, q);
    end
    stim_done = 1;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    wait (stim_done && rst_ni);
    while (pending_orders.size() > 0 || expected_events.size() > 0 || start) begin
      @(posedge clk_i);
      if (idle_cycles > StallLimit) begin
        $display("limit_order_book_matcher_unit regression: fail");
        $finish;
      end
    end
    repeat (3 * (Depth + 3) + 10) @(posedge clk_i);
    if (errors == 0 && expected_events.size() == 0) begin
      $display("limit_order_book_matcher_unit regression: pass");
    end else begin
      $display("limit_order_book_matcher_unit regression: fail");
    end
    $finish;
  end

endmodule
